// File: rtl/spwm_pkg.sv
// Shared types and constants for the servo PWM to PPM converter.
package spwm_pkg;

   localparam int PINS_W  = 4;
   localparam int CFG_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CHAN_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_MASK = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_OFFSET = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_HIGH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_BASE     = 3'd4;

   localparam logic [PINS_W-1:0] RST_TRIGGER_MASK = 4'd2;
   localparam logic [CFG_W-1:0]  RST_DEBOUNCE     = 16'd100;
   localparam logic [CFG_W-1:0]  RST_WIDTH_OFFSET = 16'd1000;
   localparam logic [CFG_W-1:0]  RST_SYNC_HIGH    = 16'd400;
   localparam logic [CFG_W-1:0]  RST_GAP_BASE     = 16'd600;

   typedef enum logic [2:0] {
      PH_WAIT = 3'd0,
      PH_DEB  = 3'd1,
      PH_MEAS = 3'd2,
      PH_SYNC = 3'd3,
      PH_LOW  = 3'd4,
      PH_STOP = 3'd5
   } phase_type;

   typedef struct packed {
      logic clear;
      logic measure;
      logic finish;
   } lane_ctl_type;

   typedef struct packed {
      logic              ppm_level;
      logic [2:0]        phase;
      logic [CHAN_W-1:0] channel;
      logic              frame_end;
   } rsp_type;

endpackage

// File: rtl/spwm_channels_if.sv
// Handshake channel interfaces: pin samples in, PPM tick results out.
interface spwm_req_if;
   logic                           valid;
   logic                           ready;
   logic [spwm_pkg::PINS_W-1:0]    pins;

   modport source (output valid, output pins, input ready);
   modport sink   (input valid, input pins, output ready);
endinterface

interface spwm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           ppm_level;
   logic [2:0]                     phase;
   logic [spwm_pkg::CHAN_W-1:0]    channel;
   logic                           frame_end;

   modport source (output valid, output ppm_level, output phase, output channel,
                   output frame_end, input ready);
   modport sink   (input valid, input ppm_level, input phase, input channel,
                   input frame_end, output ready);
endinterface

// File: rtl/spwm_lane.sv
// One channel lane: first-low capture, seen tracking and offset removal.
module spwm_lane #(
   parameter int COUNT_BITS = 16
) (
   input  logic                          clock,
   input  logic                          pin,
   input  spwm_pkg::lane_ctl_type        ctl,
   input  logic [COUNT_BITS-1:0]         tick_count,
   input  logic [spwm_pkg::CFG_W-1:0]    width_offset,
   output logic                          seen_now,
   output logic [COUNT_BITS-1:0]         width
);

   localparam int WB = (COUNT_BITS > spwm_pkg::CFG_W) ? COUNT_BITS : spwm_pkg::CFG_W;

   logic                  captured_ff, captured_in;
   logic                  seen_ff, seen_in;
   logic [COUNT_BITS-1:0] width_ff, width_in;
   logic                  low;
   logic                  fresh;
   logic [COUNT_BITS-1:0] cap;
   logic [WB-1:0]         cap_w;
   logic [WB-1:0]         off_w;
   logic [COUNT_BITS-1:0] trimmed;

   assign low      = ~pin;
   assign fresh    = low & ~captured_ff;
   assign cap      = fresh ? tick_count : width_ff;
   assign cap_w    = WB'(cap);
   assign off_w    = WB'(width_offset);
   assign trimmed  = (cap_w < off_w) ? '0 : COUNT_BITS'(cap_w - off_w);
   assign seen_now = seen_ff | low;

   always_comb begin
      captured_in = captured_ff;
      seen_in     = seen_ff;
      width_in    = width_ff;
      if (ctl.clear) begin
         captured_in = 1'b0;
         seen_in     = 1'b0;
         width_in    = '0;
      end else if (ctl.measure) begin
         captured_in = captured_ff | low;
         seen_in     = seen_now;
         width_in    = ctl.finish ? trimmed : cap;
      end
   end

   always_ff @(posedge clock) begin
      captured_ff <= captured_in;
      seen_ff     <= seen_in;
      width_ff    <= width_in;
   end

   assign width = width_ff;

endmodule

// File: rtl/spwm_seq.sv
// Frame sequencer: tick counter, phase control and merge of lane results.
module spwm_seq #(
   parameter int CHANNELS   = 4,
   parameter int COUNT_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [spwm_pkg::PINS_W-1:0]   pins_live,
   input  logic [spwm_pkg::PINS_W-1:0]   trigger_mask,
   input  logic [spwm_pkg::CFG_W-1:0]    debounce_ticks,
   input  logic [spwm_pkg::CFG_W-1:0]    sync_high_ticks,
   input  logic [spwm_pkg::CFG_W-1:0]    gap_base_ticks,
   input  logic [CHANNELS-1:0]           lane_seen,
   input  logic [COUNT_BITS-1:0]         lane_width [CHANNELS],
   output spwm_pkg::lane_ctl_type        lane_ctl,
   output logic [COUNT_BITS-1:0]         tick_count,
   output spwm_pkg::rsp_type             result
);

   localparam int SEL_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int LW    = ((COUNT_BITS > spwm_pkg::CFG_W) ? COUNT_BITS : spwm_pkg::CFG_W) + 1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   spwm_pkg::phase_type   phase_ff, phase_in;
   logic [COUNT_BITS-1:0] tick_ff, tick_in;
   logic [SEL_W-1:0]      send_ff, send_in;

   logic [COUNT_BITS-1:0] tick_inc;
   logic [COUNT_BITS:0]   tick_plus;
   logic [COUNT_BITS-1:0] width_sel;
   logic [LW-1:0]         len_raw;
   logic [COUNT_BITS-1:0] len_n;
   logic [LW-1:0]         deb_w;
   logic [COUNT_BITS-1:0] deb_target;
   logic                  interval_done;
   logic                  all_seen;
   logic                  last_chan;
   logic                  go_wait;
   logic                  frame_end;
   logic [31:0]           send_wide;

   assign tick_inc   = tick_ff + 1'b1;
   assign tick_plus  = {1'b0, tick_ff} + 1'b1;
   assign width_sel  = (32'(send_ff) < CHANNELS) ? lane_width[send_ff] : '0;
   assign len_raw    = (phase_ff == spwm_pkg::PH_LOW) ?
                       LW'(width_sel) + LW'(gap_base_ticks) : LW'(sync_high_ticks);
   assign len_n      = (len_raw == '0) ? COUNT_BITS'(1) :
                       (len_raw > LW'(COUNT_MAX)) ? COUNT_MAX : len_raw[COUNT_BITS-1:0];
   assign interval_done = tick_plus >= {1'b0, len_n};
   assign deb_w      = LW'(debounce_ticks);
   assign deb_target = (deb_w > LW'(COUNT_MAX)) ? COUNT_MAX : deb_w[COUNT_BITS-1:0];
   assign all_seen   = &lane_seen;
   assign last_chan  = (32'(send_ff) + 32'd1) >= CHANNELS;
   assign send_wide  = 32'(send_ff);
   assign tick_count = tick_ff;

   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      send_in   = send_ff;
      go_wait   = 1'b0;
      frame_end = 1'b0;
      lane_ctl  = '0;
      unique case (phase_ff)
         spwm_pkg::PH_WAIT: begin
            if ((pins_live & trigger_mask) == trigger_mask) begin
               phase_in = spwm_pkg::PH_DEB;
               tick_in  = '0;
            end
         end
         spwm_pkg::PH_DEB: begin
            if (tick_ff >= deb_target) phase_in = spwm_pkg::PH_MEAS;
            tick_in = tick_inc;
         end
         spwm_pkg::PH_MEAS: begin
            lane_ctl.measure = step;
            lane_ctl.finish  = all_seen;
            tick_in = tick_inc;
            if (all_seen) begin
               phase_in = spwm_pkg::PH_SYNC;
               tick_in  = '0;
               send_in  = '0;
            end
         end
         spwm_pkg::PH_SYNC: begin
            tick_in = tick_inc;
            if (interval_done) begin
               tick_in  = '0;
               phase_in = spwm_pkg::PH_LOW;
            end
         end
         spwm_pkg::PH_LOW: begin
            tick_in = tick_inc;
            if (interval_done) begin
               tick_in = '0;
               if (last_chan) begin
                  phase_in = spwm_pkg::PH_STOP;
               end else begin
                  send_in  = send_ff + 1'b1;
                  phase_in = spwm_pkg::PH_SYNC;
               end
            end
         end
         spwm_pkg::PH_STOP: begin
            tick_in = tick_inc;
            if (interval_done) begin
               frame_end = 1'b1;
               go_wait   = 1'b1;
            end
         end
         default: begin
            go_wait = 1'b1;
         end
      endcase
      if (go_wait) begin
         phase_in = spwm_pkg::PH_WAIT;
         tick_in  = '0;
         send_in  = '0;
      end
      lane_ctl.clear = reset | (step & go_wait);

      result.ppm_level = (phase_ff == spwm_pkg::PH_SYNC) || (phase_ff == spwm_pkg::PH_STOP);
      result.phase     = phase_ff;
      result.channel   = ((phase_ff == spwm_pkg::PH_SYNC) || (phase_ff == spwm_pkg::PH_LOW)) ?
                         send_wide[spwm_pkg::CHAN_W-1:0] : '0;
      result.frame_end = frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= spwm_pkg::PH_WAIT;
         tick_ff  <= '0;
         send_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         send_ff  <= send_in;
      end
   end

   a_wait_clean: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == spwm_pkg::PH_WAIT) |-> (send_ff == '0) && (tick_ff == '0))
      else $error("wait phase with stale counters");

   a_frame_end_wait: assert property (@(posedge clock) disable iff (reset)
      (step && result.frame_end) |=> (phase_ff == spwm_pkg::PH_WAIT))
      else $error("frame end did not return to wait");

   a_measure_done: assert property (@(posedge clock) disable iff (reset)
      (step && (phase_ff == spwm_pkg::PH_MEAS) && all_seen) |=>
      (phase_ff == spwm_pkg::PH_SYNC) && (tick_ff == '0) && (send_ff == '0))
      else $error("measurement end did not start frame");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(tick_ff) && $stable(send_ff))
      else $error("sequencer moved without a transfer");

endmodule

// File: rtl/spwm_skid.sv
// Two-entry output register with skid stage for the result channel.
module spwm_skid (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  spwm_pkg::rsp_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output spwm_pkg::rsp_type out_data
);

   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   spwm_pkg::rsp_type out_data_ff, out_data_in;
   spwm_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              in_fire;

   assign in_ready  = ~skid_valid_ff;
   assign in_fire   = in_valid & ~skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_data_in  = in_data;
            out_valid_in = in_fire;
         end
      end else if (in_fire) begin
         skid_data_in  = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

endmodule

// File: rtl/servo_pwm_to_ppm_converter.sv
// Top level: four servo PWM inputs measured in parallel lanes, re-sent as one PPM frame.
//
// req carries one timer tick per transfer: pins holds the sampled servo levels,
// bit n for channel n. rsp returns exactly one result per accepted tick, in order:
// the PPM line level, the phase, the channel being sent and a frame end flag, all
// describing the tick just taken.
// csr_we/csr_index/csr_wdata write the five settings (trigger mask, debounce,
// width offset, sync high length, gap base); a write lands on the next clock and
// an unknown index is dropped. Write only while the block is idle.
// Throughput is one tick per clock while rsp is not stalled. A result reaches rsp
// through the output register after its tick is taken; a second result can be held in the
// skid stage, so req stays ready for one more transfer while rsp is stalled and
// drops ready only when both entries are full.
// Reset (synchronous, active high) restores the default settings, returns the
// sequencer to the trigger wait and clears all lane widths and flags.
module servo_pwm_to_ppm_converter #(
   parameter int CHANNELS   = 4,
   parameter int COUNT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   spwm_req_if.sink                          req,
   spwm_rsp_if.source                        rsp,
   input  logic                              csr_we,
   input  logic [spwm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [spwm_pkg::CFG_W-1:0]        csr_wdata
);

   logic [spwm_pkg::PINS_W-1:0] trigger_mask_ff;
   logic [spwm_pkg::CFG_W-1:0]  debounce_ff;
   logic [spwm_pkg::CFG_W-1:0]  width_offset_ff;
   logic [spwm_pkg::CFG_W-1:0]  sync_high_ff;
   logic [spwm_pkg::CFG_W-1:0]  gap_base_ff;

   logic [spwm_pkg::PINS_W-1:0] pins_live;
   logic                        step;
   logic                        req_ready;
   logic [CHANNELS-1:0]         lane_seen;
   logic [COUNT_BITS-1:0]       lane_width [CHANNELS];
   logic [CHANNELS-1:0]         lane_pin;
   spwm_pkg::lane_ctl_type      lane_ctl;
   logic [COUNT_BITS-1:0]       tick_count;
   spwm_pkg::rsp_type           result;
   spwm_pkg::rsp_type           rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_mask_ff <= spwm_pkg::RST_TRIGGER_MASK;
         debounce_ff     <= spwm_pkg::RST_DEBOUNCE;
         width_offset_ff <= spwm_pkg::RST_WIDTH_OFFSET;
         sync_high_ff    <= spwm_pkg::RST_SYNC_HIGH;
         gap_base_ff     <= spwm_pkg::RST_GAP_BASE;
      end else if (csr_we) begin
         unique case (csr_index)
            spwm_pkg::CSR_TRIGGER_MASK: trigger_mask_ff <= csr_wdata[spwm_pkg::PINS_W-1:0];
            spwm_pkg::CSR_DEBOUNCE:     debounce_ff     <= csr_wdata;
            spwm_pkg::CSR_WIDTH_OFFSET: width_offset_ff <= csr_wdata;
            spwm_pkg::CSR_SYNC_HIGH:    sync_high_ff    <= csr_wdata;
            spwm_pkg::CSR_GAP_BASE:     gap_base_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < spwm_pkg::PINS_W; i++) begin
         pins_live[i] = req.pins[i] && (i < CHANNELS);
      end
   end

   assign req.ready = req_ready;
   assign step      = req.valid & req_ready;

   for (genvar n = 0; n < CHANNELS; n++) begin : g_lane
      if (n < spwm_pkg::PINS_W) begin : g_pin
         assign lane_pin[n] = pins_live[n];
      end else begin : g_nopin
         assign lane_pin[n] = 1'b0;
      end

      spwm_lane #(
         .COUNT_BITS(COUNT_BITS)
      ) u_lane (
         .clock        (clock),
         .pin          (lane_pin[n]),
         .ctl          (lane_ctl),
         .tick_count   (tick_count),
         .width_offset (width_offset_ff),
         .seen_now     (lane_seen[n]),
         .width        (lane_width[n])
      );
   end

   spwm_seq #(
      .CHANNELS   (CHANNELS),
      .COUNT_BITS (COUNT_BITS)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .pins_live       (pins_live),
      .trigger_mask    (trigger_mask_ff),
      .debounce_ticks  (debounce_ff),
      .sync_high_ticks (sync_high_ff),
      .gap_base_ticks  (gap_base_ff),
      .lane_seen       (lane_seen),
      .lane_width      (lane_width),
      .lane_ctl        (lane_ctl),
      .tick_count      (tick_count),
      .result          (result)
   );

   spwm_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req_ready),
      .in_data   (result),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (rsp_data)
   );

   assign rsp.ppm_level = rsp_data.ppm_level;
   assign rsp.phase     = rsp_data.phase;
   assign rsp.channel   = rsp_data.channel;
   assign rsp.frame_end = rsp_data.frame_end;

endmodule
